// ----- design/mvpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvpm_pkg
// Types, constants and helpers shared by the multi-voice PCM mixer modules.
// ----------------------------------------------------------------------------
package mvpm_pkg;

    localparam int VOICES       = 32;
    localparam int SAMPLE_DEPTH = 65536;

    localparam int SLOT_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MEM_AW  = $clog2(SAMPLE_DEPTH);
    localparam int VSLOT_W = 5;
    localparam int LEN_W   = 17;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_QUEUE,
        OP_TICK
    } op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [LEN_W-1:0]   sound_length;
    } item_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               status;
        logic [VSLOT_W-1:0] voice_slot;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [MEM_AW-1:0]  address;
        logic signed [15:0] sample_value;
        logic [LEN_W-1:0]   sound_length;
    } work_t;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        logic signed [15:0] r;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15])
        begin
            r = s[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/mvpm_front.sv -----
// ----------------------------------------------------------------------------
// mvpm_front
// Accepts command items, decodes them into operations and holds them in a
// short queue for the execution side.
// ----------------------------------------------------------------------------
module mvpm_front
    import mvpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  work_valid,
    input  logic  work_ready,
    output work_t work
);

    work_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    work_t              decoded;
    logic               push;
    logic               pop;

    always_comb
    begin
        decoded.address      = MEM_AW'(item.address);
        decoded.sample_value = item.sample_value;
        decoded.sound_length = item.sound_length;
        unique case (item.cmd)
            CMD_LOAD:  decoded.op = OP_LOAD;
            CMD_QUEUE: decoded.op = (item.sound_length != '0) ? OP_QUEUE : OP_NONE;
            CMD_TICK:  decoded.op = OP_TICK;
            default:   decoded.op = OP_NONE;
        endcase
    end

    assign item_ready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign work_valid = (count_reg != '0);
    assign work       = q_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = work_valid && work_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/mvpm_back.sv -----
// ----------------------------------------------------------------------------
// mvpm_back
// Executes decoded operations: sample memory writes, voice slot allocation
// by a slot scan, and the per-tick mix that visits every slot in order.
// ----------------------------------------------------------------------------
module mvpm_back
    import mvpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    work_valid,
    output logic    work_ready,
    input  work_t   work,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_TICK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t              state_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [VOICES-1:0]   voice_active_reg;
    logic [MEM_AW-1:0]   voice_addr_reg [VOICES];
    logic [LEN_W-1:0]    voice_rem_reg [VOICES];
    work_t               cur_reg;
    logic signed [15:0]  sum_reg;
    logic                status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                pipe_valid_reg;
    logic signed [15:0]  rd_data_reg;
    logic [15:0]         mem [SAMPLE_DEPTH];
    logic                result_valid_reg;
    result_t             result_reg;

    logic                last_slot;
    logic                idx_free;
    logic                claim;
    logic                step;
    logic [LEN_W-1:0]    rem_dec;
    logic                mem_we;
    logic                out_free;

    assign last_slot  = (idx_reg == SLOT_W'(VOICES - 1));
    assign idx_free   = !voice_active_reg[idx_reg];
    assign claim      = (state_reg == ST_SCAN) && idx_free;
    assign step       = (state_reg == ST_TICK) && voice_active_reg[idx_reg];
    assign rem_dec    = voice_rem_reg[idx_reg] - 1'b1;
    assign work_ready = (state_reg == ST_IDLE);
    assign mem_we     = work_ready && work_valid && (work.op == OP_LOAD);
    assign out_free   = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[work.address] <= work.sample_value;
        end
        if (step)
        begin
            rd_data_reg <= mem[voice_addr_reg[idx_reg]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            voice_addr_reg[idx_reg] <= cur_reg.address;
            voice_rem_reg[idx_reg]  <= cur_reg.sound_length;
        end
        else if (step)
        begin
            voice_addr_reg[idx_reg] <= voice_addr_reg[idx_reg] + 1'b1;
            voice_rem_reg[idx_reg]  <= rem_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_ready && work_valid)
        begin
            cur_reg    <= work;
            sum_reg    <= '0;
            status_reg <= 1'b0;
            slot_reg   <= '0;
        end
        else
        begin
            if (pipe_valid_reg)
            begin
                sum_reg <= sat_add(sum_reg, rd_data_reg);
            end
            if (claim)
            begin
                slot_reg <= idx_reg;
            end
            else if ((state_reg == ST_SCAN) && last_slot)
            begin
                status_reg <= 1'b1;
            end
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            result_reg.mixed_sample <= sum_reg;
            result_reg.status       <= status_reg;
            result_reg.voice_slot   <= VSLOT_W'(slot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            voice_active_reg <= '0;
            pipe_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_RESULT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    pipe_valid_reg <= 1'b0;
                    idx_reg        <= '0;
                    if (work_valid)
                    begin
                        unique case (work.op)
                            OP_QUEUE: state_reg <= ST_SCAN;
                            OP_TICK:  state_reg <= ST_TICK;
                            default:  state_reg <= ST_RESULT;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (idx_free)
                    begin
                        voice_active_reg[idx_reg] <= 1'b1;
                        state_reg <= ST_RESULT;
                    end
                    else if (last_slot)
                    begin
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_TICK:
                begin
                    pipe_valid_reg <= step;
                    if (step && (rem_dec == '0))
                    begin
                        voice_active_reg[idx_reg] <= 1'b0;
                    end
                    if (last_slot)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    pipe_valid_reg <= 1'b0;
                    state_reg      <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/multi_voice_pcm_mixer_core.sv -----
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_core
// Sample memory and voice mixer with a decoupled command front end.
// ----------------------------------------------------------------------------
// Every command transfer gives exactly one result transfer, in order. A
// queue scans the voice slots one per cycle from slot zero and stops at the
// first free one. A tick visits every voice slot once, one per cycle,
// through the single read port of the sample memory. A two-entry command
// queue lets new commands be taken while one executes, and the result
// register lets execution go on while a result waits to be taken. Reading
// a sample word that was never loaded gives an undefined value.
module multi_voice_pcm_mixer_core
    import mvpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic  work_valid;
    logic  work_ready;
    work_t work;

    mvpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work)
    );

    mvpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (work_valid),
        .work_ready   (work_ready),
        .work         (work),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- design/mvpm_checker.sv -----
// ----------------------------------------------------------------------------
// mvpm_checker
// Port-level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
module mvpm_checker
    import mvpm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("Command changed or dropped while stalled.");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("Result changed or dropped while stalled.");

    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.voice_slot == '0)
        else $error("Rejected queue reports a slot.");

    a_full_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.mixed_sample == '0)
        else $error("Rejected queue reports a mix value.");

    a_slot_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.voice_slot != '0) |-> result.mixed_sample == '0)
        else $error("Queue result carries a mix value.");

endmodule

bind multi_voice_pcm_mixer_core mvpm_checker u_checker (.*);
